/* rtl/core/mvm_pkg.sv */
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared constants, codes and types of the matrix-vector multiply unit.
// ----------------------------------------------------------------------------
package mvm_pkg;

   localparam int MAX_DIM    = 64;
   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 8;

   localparam int ADDR_WIDTH = 12;
   localparam int OUT_IDX_W  = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int IDX_W     = $clog2(MAX_DIM);
   localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
   localparam int MADDR_W   = $clog2(MAT_DEPTH);

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic ACT_MATRIX = 1'b0;
   localparam logic ACT_VECTOR = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_ROWS  = 2'd0,
      CSR_NUM_COLS  = 2'd1,
      CSR_TRANSPOSE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_MAT_WRITE,
      CMD_VEC_WRITE,
      CMD_VEC_RUN
   } cmd_kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

   typedef struct packed {
      cmd_kind_type                  kind;
      logic                          wr_en;
      logic [ADDR_WIDTH-1:0]         addr;
      logic signed [DATA_WIDTH-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] cols;
      logic             transpose;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last;
      logic             vec_end;
      logic [IDX_W-1:0] k;
   } tag_type;

endpackage

/* rtl/core/matrix_vector_multiply_unit.sv */
// ----------------------------------------------------------------------------
// matrix_vector_multiply_unit
// Matrix-vector and transposed matrix-vector product over signed Q8.8 words.
// ----------------------------------------------------------------------------
// A request is taken whenever the four-entry command queue has room; busy
// is high while it is full. Store writes retire one per cycle while no
// product is running. A request with vector_last runs on the single shared
// multiply-accumulate unit, and its results strobe out one product element
// at a time. Reset clears the queue, pipeline and registers (64 by 64,
// normal mode); stores keep no reset.
module matrix_vector_multiply_unit import mvm_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [ADDR_WIDTH-1:0]         req_addr,
   input  logic signed [DATA_WIDTH-1:0]  req_element_value,
   input  logic                          req_vector_last,
   output logic                          rsp_strobe,
   output logic [OUT_IDX_W-1:0]          rsp_out_index,
   output logic signed [DATA_WIDTH-1:0]  rsp_out_value,
   output logic                          rsp_out_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int RESET_DIM = (MAX_DIM < 64) ? MAX_DIM : 64;

   cfg_type           cfg_ff, cfg_in;
   logic [DIM_W-1:0]  dim_val;
   logic [OUT_IDX_W-1:0] exp_last_idx;
   fifo_stat_type     fifo_stat;
   cmd_type           push_cmd, head_cmd;
   logic              fifo_push, fifo_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      priority if (csr_data == '0) begin
         dim_val = DIM_W'(1);
      end else if (32'(csr_data) > MAX_DIM) begin
         dim_val = DIM_W'(MAX_DIM);
      end else begin
         dim_val = DIM_W'(csr_data);
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NUM_ROWS:  cfg_in.rows      = dim_val;
            CSR_NUM_COLS:  cfg_in.cols      = dim_val;
            CSR_TRANSPOSE: cfg_in.transpose = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows      <= DIM_W'(RESET_DIM);
         cfg_ff.cols      <= DIM_W'(RESET_DIM);
         cfg_ff.transpose <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mvm_front u_front (
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_addr          (req_addr),
      .req_element_value (req_element_value),
      .req_vector_last   (req_vector_last),
      .fifo_stat         (fifo_stat),
      .push              (fifo_push),
      .push_cmd          (push_cmd)
   );

   mvm_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (fifo_push),
      .push_cmd (push_cmd),
      .pop      (fifo_pop),
      .head_cmd (head_cmd),
      .stat     (fifo_stat)
   );

   mvm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head_cmd      (head_cmd),
      .stat          (fifo_stat),
      .pop           (fifo_pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_index (rsp_out_index),
      .rsp_out_value (rsp_out_value),
      .rsp_out_last  (rsp_out_last)
   );

   assign exp_last_idx =
      OUT_IDX_W'((cfg_ff.transpose ? cfg_ff.cols : cfg_ff.rows) - DIM_W'(1));

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_out_last |-> rsp_out_index == exp_last_idx)
      else $error("final result index does not match the product length");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_out_last |=>
         !rsp_strobe || (rsp_out_index == $past(rsp_out_index) + 6'd1))
      else $error("result index did not advance by one");

   a_index_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_out_last |=> !rsp_strobe || rsp_out_index == '0)
      else $error("new product vector did not start at index zero");

endmodule

/* rtl/core/mvm_front.sv */
// ----------------------------------------------------------------------------
// mvm_front
// Accepts requests, classifies them and range-checks their addresses.
// ----------------------------------------------------------------------------
module mvm_front import mvm_pkg::*; (
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [ADDR_WIDTH-1:0]         req_addr,
   input  logic signed [DATA_WIDTH-1:0]  req_element_value,
   input  logic                          req_vector_last,
   input  fifo_stat_type                 fifo_stat,
   output logic                          push,
   output cmd_type                       push_cmd
);

   assign busy = fifo_stat.full;
   assign push = start && !fifo_stat.full;

   always_comb begin
      push_cmd.addr  = req_addr;
      push_cmd.value = req_element_value;
      unique case (req_action)
         ACT_MATRIX: begin
            push_cmd.kind  = CMD_MAT_WRITE;
            push_cmd.wr_en = 32'(req_addr) < MAT_DEPTH;
         end
         ACT_VECTOR: begin
            push_cmd.kind  = req_vector_last ? CMD_VEC_RUN : CMD_VEC_WRITE;
            push_cmd.wr_en = 32'(req_addr) < MAX_DIM;
         end
         default: begin
            push_cmd.kind  = CMD_MAT_WRITE;
            push_cmd.wr_en = 1'b0;
         end
      endcase
   end

endmodule

/* rtl/core/mvm_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// mvm_cmd_fifo
// Short command queue between the request front end and the datapath.
// ----------------------------------------------------------------------------
module mvm_cmd_fifo import mvm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_type       push_cmd,
   input  logic          pop,
   output cmd_type       head_cmd,
   output fifo_stat_type stat
);

   cmd_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;

   assign stat.full  = count_ff == FIFO_CNT_W'(FIFO_DEPTH);
   assign stat.empty = count_ff == '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/core/mvm_back.sv */
// ----------------------------------------------------------------------------
// mvm_back
// Executes queued commands: store writes, and the multiply-accumulate
// sequencer with its read, multiply, accumulate and rounding stages.
// ----------------------------------------------------------------------------
module mvm_back import mvm_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  cmd_type                       head_cmd,
   input  fifo_stat_type                 stat,
   output logic                          pop,
   output logic                          rsp_strobe,
   output logic [OUT_IDX_W-1:0]          rsp_out_index,
   output logic signed [DATA_WIDTH-1:0]  rsp_out_value,
   output logic                          rsp_out_last
);

   localparam int ACC_W = 2 * DATA_WIDTH + IDX_W + 1;
   localparam int HALF  = (1 << FRAC_BITS) >> 1;
   localparam logic signed [ACC_W-1:0] SAT_HI =
      ACC_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

   back_state_type           state_ff, state_in;
   logic [IDX_W-1:0]         k_ff, k_in;
   logic [IDX_W-1:0]         t_ff, t_in;
   logic [MADDR_W-1:0]       addr_ff, addr_in;
   logic [DIM_W-1:0]         len_ff, len_in;
   logic [DIM_W-1:0]         terms_ff, terms_in;
   logic [DIM_W-1:0]         cols_ff, cols_in;
   logic                     trans_ff, trans_in;
   logic                     issue, mat_we, vec_we;
   logic                     t_last, k_last;

   logic signed [DATA_WIDTH-1:0]    matrix_mem [MAT_DEPTH];
   logic signed [DATA_WIDTH-1:0]    vector_mem [MAX_DIM];
   logic signed [DATA_WIDTH-1:0]    mat_rd_ff, vec_rd_ff;
   logic signed [2*DATA_WIDTH-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]         acc_ff, acc_in, acc_base, prod_ext;
   logic signed [ACC_W-1:0]         rnd, shr;
   logic signed [DATA_WIDTH-1:0]    sat_val;

   tag_type  tag_issue, s1_ff, s2_ff, s3_ff;

   logic                          strobe_ff;
   logic [OUT_IDX_W-1:0]          index_ff;
   logic signed [DATA_WIDTH-1:0]  value_ff;
   logic                          last_ff;

   assign t_last = (DIM_W'(t_ff) + DIM_W'(1)) == terms_ff;
   assign k_last = (DIM_W'(k_ff) + DIM_W'(1)) == len_ff;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      t_in     = t_ff;
      addr_in  = addr_ff;
      len_in   = len_ff;
      terms_in = terms_ff;
      cols_in  = cols_ff;
      trans_in = trans_ff;
      pop      = 1'b0;
      mat_we   = 1'b0;
      vec_we   = 1'b0;
      issue    = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!stat.empty) begin
               pop = 1'b1;
               unique case (head_cmd.kind)
                  CMD_MAT_WRITE: begin
                     mat_we = head_cmd.wr_en;
                  end
                  CMD_VEC_WRITE: begin
                     vec_we = head_cmd.wr_en;
                  end
                  CMD_VEC_RUN: begin
                     vec_we   = head_cmd.wr_en;
                     state_in = BK_RUN;
                     k_in     = '0;
                     t_in     = '0;
                     addr_in  = '0;
                     trans_in = cfg.transpose;
                     cols_in  = cfg.cols;
                     len_in   = cfg.transpose ? cfg.cols : cfg.rows;
                     terms_in = cfg.transpose ? cfg.rows : cfg.cols;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_RUN: begin
            issue = 1'b1;
            if (t_last) begin
               t_in    = '0;
               addr_in = trans_ff ? MADDR_W'(k_ff) + MADDR_W'(1) : addr_ff + MADDR_W'(1);
               if (k_last) begin
                  state_in = BK_IDLE;
               end else begin
                  k_in = k_ff + IDX_W'(1);
               end
            end else begin
               t_in    = t_ff + IDX_W'(1);
               addr_in = trans_ff ? addr_ff + MADDR_W'(cols_ff) : addr_ff + MADDR_W'(1);
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      t_ff     <= t_in;
      addr_ff  <= addr_in;
      len_ff   <= len_in;
      terms_ff <= terms_in;
      cols_ff  <= cols_in;
      trans_ff <= trans_in;
   end

   always_ff @(posedge clock) begin
      if (mat_we) begin
         matrix_mem[MADDR_W'(head_cmd.addr)] <= head_cmd.value;
      end
      mat_rd_ff <= matrix_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (vec_we) begin
         vector_mem[IDX_W'(head_cmd.addr)] <= head_cmd.value;
      end
      vec_rd_ff <= vector_mem[t_ff];
   end

   always_comb begin
      tag_issue.valid   = issue;
      tag_issue.first   = t_ff == '0;
      tag_issue.last    = t_last;
      tag_issue.vec_end = t_last && k_last;
      tag_issue.k       = k_ff;
   end

   assign prod_in  = mat_rd_ff * vec_rd_ff;
   assign prod_ext = ACC_W'(prod_ff);
   assign acc_base = s2_ff.first ? ACC_W'(0) : acc_ff;
   assign acc_in   = acc_base + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
      end else begin
         s1_ff <= tag_issue;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (s2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      rnd = acc_ff + ACC_W'(HALF);
      shr = rnd >>> FRAC_BITS;
      priority if (shr > SAT_HI) begin
         sat_val = SAT_HI[DATA_WIDTH-1:0];
      end else if (shr < SAT_LO) begin
         sat_val = SAT_LO[DATA_WIDTH-1:0];
      end else begin
         sat_val = shr[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= s3_ff.valid && s3_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      index_ff <= OUT_IDX_W'(s3_ff.k);
      value_ff <= sat_val;
      last_ff  <= s3_ff.vec_end;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_out_index = index_ff;
   assign rsp_out_value = value_ff;
   assign rsp_out_last  = last_ff && strobe_ff;

endmodule

/* tb/matrix_vector_multiply_unit_tb.sv */
// ----------------------------------------------------------------------------
// matrix_vector_multiply_unit_tb
// Self-checking testbench for the matrix-vector multiply unit. A queue of
// requests feeds a clocked driver with random gaps, a clocked monitor keeps
// its own copy of the stores and registers, predicts every product element
// and checks each strobed result against the oldest prediction. Directed
// cases cover saturation, rounding and ignored requests; random phases vary
// the matrix size and orientation, including the out-of-range settings.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_unit_tb import mvm_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES  = 4;
   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT   = 2000;
   localparam int TARGET_COUNT  = 380;
   localparam int PRINT_CAP     = 100;

   typedef struct {
      logic                          action;
      logic [ADDR_WIDTH-1:0]         addr;
      logic signed [DATA_WIDTH-1:0]  value;
      logic                          last;
   } mvm_request_type;

   typedef struct {
      logic [OUT_IDX_W-1:0]          index;
      logic signed [DATA_WIDTH-1:0]  value;
      logic                          last;
   } product_word_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_action = ACT_MATRIX;
   logic [ADDR_WIDTH-1:0]         req_addr = '0;
   logic signed [DATA_WIDTH-1:0]  req_element_value = '0;
   logic                          req_vector_last = 1'b0;
   logic                          rsp_strobe;
   logic [OUT_IDX_W-1:0]          rsp_out_index;
   logic signed [DATA_WIDTH-1:0]  rsp_out_value;
   logic                          rsp_out_last;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   csr_index_type                 csr_index = CSR_NUM_ROWS;
   logic [CSR_DATA_W-1:0]         csr_data = '0;

   mvm_request_type   pending_requests[$];
   product_word_type  expected_products[$];

   logic signed [DATA_WIDTH-1:0]  mat_words [MAT_DEPTH];
   logic signed [DATA_WIDTH-1:0]  vec_words [MAX_DIM];
   logic [CSR_DATA_W-1:0]         cfg_rows = CSR_DATA_W'(64);
   logic [CSR_DATA_W-1:0]         cfg_cols = CSR_DATA_W'(64);
   logic                          cfg_transpose = 1'b0;

   bit  mat_loaded [MAT_DEPTH];
   bit  vec_loaded [MAX_DIM];
   int  gen_rows = 64;
   int  gen_cols = 64;
   bit  gen_transpose = 1'b0;
   bit  calm_phase = 1'b0;

   int  queued_count = 0;
   int  accepted_count = 0;
   int  gap_left = 0;
   int  idle_cycles = 0;
   int  mismatches = 0;

   matrix_vector_multiply_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_addr          (req_addr),
      .req_element_value (req_element_value),
      .req_vector_last   (req_vector_last),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_index     (rsp_out_index),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_last      (rsp_out_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #6 clock = ~clock;

   function automatic int eff_dim(int value);
      if (value == 0) begin
         return 1;
      end
      if (value > MAX_DIM) begin
         return MAX_DIM;
      end
      return value;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm_phase || roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [DATA_WIDTH-1:0] rand_word();
      int roll;
      int value;
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         value = int'($urandom_range(0, 512)) - 256;
      end else if (roll < 60) begin
         value = int'($urandom_range(0, 4096)) - 2048;
      end else if (roll < 85) begin
         value = int'($urandom());
      end else begin
         case ($urandom_range(0, 4))
            0: value = -32768;
            1: value = 32767;
            2: value = 0;
            3: value = -1;
            default: value = 1;
         endcase
      end
      return value[DATA_WIDTH-1:0];
   endfunction

   function automatic int pick_dim();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $urandom_range(MAX_DIM + 1, 127);
         2: return $urandom_range(9, MAX_DIM);
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   task automatic flag_mismatch(input string what);
      if (mismatches < PRINT_CAP) begin
         $display("ERROR at %0t: %s", $time, what);
      end
      mismatches++;
   endtask

   // Applies one accepted request to the shadow stores and, on a vector
   // request with the last flag, queues the whole product vector.
   task automatic predict_request(input mvm_request_type rq);
      int        rows;
      int        cols;
      int        len;
      int        terms;
      int        a;
      longint    acc;
      longint    q;
      longint    hi;
      product_word_type pw;
      hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
      if (rq.action == ACT_MATRIX) begin
         mat_words[rq.addr] = rq.value;
      end else begin
         if (rq.addr < MAX_DIM) begin
            vec_words[rq.addr] = rq.value;
         end
         if (rq.last) begin
            rows  = eff_dim(int'(cfg_rows));
            cols  = eff_dim(int'(cfg_cols));
            len   = cfg_transpose ? cols : rows;
            terms = cfg_transpose ? rows : cols;
            for (int k = 0; k < len; k++) begin
               acc = 0;
               for (int t = 0; t < terms; t++) begin
                  a = cfg_transpose ? t * cols + k : k * cols + t;
                  acc += longint'(mat_words[a]) * longint'(vec_words[t]);
               end
               q = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
               if (q > hi) begin
                  q = hi;
               end else if (q < -hi - 1) begin
                  q = -hi - 1;
               end
               pw.index = k[OUT_IDX_W-1:0];
               pw.value = q[DATA_WIDTH-1:0];
               pw.last  = (k == len - 1);
               expected_products.push_back(pw);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      mvm_request_type rq;
      logic            drive;
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         drive = start;
         if (start && !busy) begin
            gap_left = pick_gap();
            drive = 1'b0;
         end
         if (!drive) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() > 0) begin
               rq = pending_requests.pop_front();
               req_action        <= rq.action;
               req_addr          <= rq.addr;
               req_element_value <= rq.value;
               req_vector_last   <= rq.last;
               drive = 1'b1;
            end
         end
         start <= drive;
      end
   end

   always @(posedge clock) begin
      mvm_request_type  rq;
      product_word_type pw;
      bit               progress;
      if (!reset) begin
         progress = 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NUM_ROWS:  cfg_rows = csr_data;
               CSR_NUM_COLS:  cfg_cols = csr_data;
               CSR_TRANSPOSE: cfg_transpose = csr_data[0];
               default: ;
            endcase
            progress = 1'b1;
         end
         if (rsp_strobe) begin
            progress = 1'b1;
            if (expected_products.size() == 0) begin
               flag_mismatch($sformatf("unexpected product index %0d value %0d",
                                       rsp_out_index, rsp_out_value));
            end else begin
               pw = expected_products.pop_front();
               if (rsp_out_index !== pw.index) begin
                  flag_mismatch($sformatf("out_index %0d, expected %0d",
                                          rsp_out_index, pw.index));
               end
               if (rsp_out_value !== pw.value) begin
                  flag_mismatch($sformatf("out_value %0d at index %0d, expected %0d",
                                          rsp_out_value, pw.index, pw.value));
               end
               if (rsp_out_last !== pw.last) begin
                  flag_mismatch($sformatf("out_last %0b at index %0d, expected %0b",
                                          rsp_out_last, pw.index, pw.last));
               end
            end
         end
         if (start && !busy) begin
            rq.action = req_action;
            rq.addr   = req_addr;
            rq.value  = req_element_value;
            rq.last   = req_vector_last;
            predict_request(rq);
            accepted_count++;
            progress = 1'b1;
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic queue_request(input logic action, input int addr,
                                input logic [DATA_WIDTH-1:0] value, input logic last);
      mvm_request_type rq;
      rq.action = action;
      rq.addr   = addr[ADDR_WIDTH-1:0];
      rq.value  = value;
      rq.last   = last;
      if (action == ACT_MATRIX) begin
         mat_loaded[rq.addr] = 1'b1;
      end else if (rq.addr < MAX_DIM) begin
         vec_loaded[rq.addr] = 1'b1;
      end
      pending_requests.push_back(rq);
      queued_count++;
   endtask

   task automatic write_csr(input csr_index_type idx, input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (queued_count != accepted_count || expected_products.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input int rows, input int cols, input bit transpose);
      write_csr(CSR_NUM_ROWS, rows);
      write_csr(CSR_NUM_COLS, cols);
      write_csr(CSR_TRANSPOSE, ($urandom_range(0, 63) << 1) | int'(transpose));
      gen_rows      = eff_dim(rows);
      gen_cols      = eff_dim(cols);
      gen_transpose = transpose;
   endtask

   task automatic queue_noise();
      case ($urandom_range(0, 3))
         0: queue_request(ACT_VECTOR, $urandom_range(MAX_DIM, MAT_DEPTH - 1),
                          rand_word(), 1'b0);
         1: queue_request(ACT_MATRIX, $urandom_range(0, MAT_DEPTH - 1), rand_word(),
                          1'b1);
         2: queue_request(ACT_VECTOR, $urandom_range(0, MAX_DIM - 1), rand_word(),
                          1'b0);
         default: queue_request(ACT_MATRIX, $urandom_range(0, MAT_DEPTH - 1),
                                rand_word(), 1'b0);
      endcase
   endtask

   // A well-formed load: some random updates inside the active region, then
   // whatever the product still needs, then the vector request that starts it.
   task automatic queue_product();
      int vlen;
      int last_addr;
      vlen = gen_transpose ? gen_rows : gen_cols;
      repeat ($urandom_range(0, 6)) begin
         queue_request(ACT_MATRIX, $urandom_range(0, gen_rows - 1) * gen_cols +
                       $urandom_range(0, gen_cols - 1), rand_word(), 1'b0);
      end
      repeat ($urandom_range(0, vlen)) begin
         queue_request(ACT_VECTOR, $urandom_range(0, vlen - 1), rand_word(), 1'b0);
      end
      if ($urandom_range(0, 7) == 0) begin
         last_addr = $urandom_range(MAX_DIM, MAT_DEPTH - 1);
      end else begin
         last_addr = $urandom_range(0, vlen - 1);
      end
      for (int i = 0; i < gen_rows; i++) begin
         for (int j = 0; j < gen_cols; j++) begin
            if (!mat_loaded[i * gen_cols + j]) begin
               queue_request(ACT_MATRIX, i * gen_cols + j, rand_word(), 1'b0);
            end
         end
      end
      for (int t = 0; t < vlen; t++) begin
         if (!vec_loaded[t] && t != last_addr) begin
            queue_request(ACT_VECTOR, t, rand_word(), 1'b0);
         end
      end
      queue_request(ACT_VECTOR, last_addr, rand_word(), 1'b1);
   endtask

   task automatic run_phase(input int rows, input int cols, input bit transpose,
                            input int products);
      drain();
      set_config(rows, cols, transpose);
      calm_phase = ($urandom_range(0, 3) == 0);
      repeat (products) begin
         repeat ($urandom_range(0, 3)) queue_noise();
         queue_product();
      end
   endtask

   initial begin
      int rows;
      int cols;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      drain();
      set_config(2, 2, 1'b0);
      queue_request(ACT_MATRIX, 0, 16'h7FFF, 1'b0);
      queue_request(ACT_MATRIX, 1, 16'h7FFF, 1'b0);
      queue_request(ACT_MATRIX, 2, 16'h8000, 1'b0);
      queue_request(ACT_MATRIX, 3, 16'h0001, 1'b0);
      queue_request(ACT_VECTOR, 0, 16'h7FFF, 1'b0);
      queue_request(ACT_VECTOR, 1, 16'h8000, 1'b1);
      queue_request(ACT_VECTOR, 0, 16'h7FFF, 1'b0);
      queue_request(ACT_VECTOR, 1, 16'h7FFF, 1'b1);
      queue_request(ACT_MATRIX, MAT_DEPTH - 1, 16'h5A5A, 1'b1);
      queue_request(ACT_VECTOR, 12'hFC0, 16'h0000, 1'b0);
      queue_request(ACT_MATRIX, 0, 16'h0001, 1'b0);
      queue_request(ACT_MATRIX, 1, 16'h0000, 1'b0);
      queue_request(ACT_MATRIX, 2, 16'hFFFF, 1'b0);
      queue_request(ACT_MATRIX, 3, 16'h0000, 1'b0);
      queue_request(ACT_VECTOR, 0, 16'h0080, 1'b0);
      queue_request(ACT_VECTOR, MAT_DEPTH - 1, 16'h7FFF, 1'b1);

      drain();
      set_config(2, 2, 1'b1);
      queue_request(ACT_VECTOR, 0, 16'h0100, 1'b0);
      queue_request(ACT_VECTOR, 1, 16'hFF00, 1'b1);

      run_phase(0, 0, 1'b0, 3);
      run_phase(127, 1, 1'b0, 2);
      run_phase(1, 127, 1'b1, 2);
      run_phase(64, 1, 1'b1, 2);

      while (queued_count < TARGET_COUNT) begin
         rows = pick_dim();
         cols = (eff_dim(rows) > 8) ? $urandom_range(0, 8) : pick_dim();
         run_phase(rows, cols, $urandom_range(0, 1), $urandom_range(2, 6));
      end

      drain();

      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
